>>> rtl/sacl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types, constants and register indexes for the cache lookup block.
// ----------------------------------------------------------------------------
package sacl_pkg;

	localparam int SET_COUNT_DEF = 256;
	localparam int WAY_COUNT_DEF = 8;
	localparam int ALIGN_BITS    = 3;
	localparam int TAG_W         = 29;
	localparam int TS_W          = 32;
	localparam int ADDR_W        = 32;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_BITS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS = 2'd3;

	// Replacement policy codes.
	localparam logic [1:0] POL_LRU  = 2'd0;
	localparam logic [1:0] POL_LFU  = 2'd1;
	localparam logic [1:0] POL_FIFO = 2'd2;

	// Per-way word held in the memory: valid bit, tag and metadata.
	typedef struct packed {
		logic             vld;
		logic [TAG_W-1:0] tag;
		logic [TS_W-1:0]  lat;
		logic [TS_W-1:0]  cnt;
		logic [TS_W-1:0]  fill;
	} way_meta_t;

	localparam int META_W = $bits(way_meta_t);

endpackage

>>> rtl/set_assoc_cache_lookup_replace.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lookup_replace
// Tag-only set-associative cache lookup with LRU, LFU or FIFO replacement.
// ----------------------------------------------------------------------------
// Usage: raise start with timestamp and address while busy is low; the
// request is taken on that edge. Each way's valid bit, tag and metadata live
// in a synchronous RAM of SET_COUNT words. The set is read into the RAMs'
// read registers as the request is taken, then compared and written back
// while act_s1 is high; the result is then registered on hit and way,
// marked by done, for one cycle. A new request is not taken while one is
// still being compared and written back, since busy stays high then.
// The receiver cannot stall; done is a single-cycle strobe.
// After reset a clearing pass writes zero to every set of every way RAM;
// busy stays high meanwhile. Registers are written through cfg_we,
// cfg_index and cfg_data while idle, a rule for the user that the block
// does not enforce; reset gives LRU, 8 index bits, no offset bits and 8 ways.
// ----------------------------------------------------------------------------
module set_assoc_cache_lookup_replace #(
	parameter int SET_COUNT = sacl_pkg::SET_COUNT_DEF,
	parameter int WAY_COUNT = sacl_pkg::WAY_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [sacl_pkg::TS_W-1:0]     timestamp,
	input  logic [sacl_pkg::ADDR_W-1:0]   address,
	output logic                          done,
	output logic                          hit,
	output logic [2:0]                    way,
	input  logic                          cfg_we,
	input  logic [sacl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sacl_pkg::*;
	localparam int SW = $clog2(SET_COUNT > 1 ? SET_COUNT : 2);
	localparam int WW = $clog2(WAY_COUNT > 1 ? WAY_COUNT : 2);

	// Configuration registers.
	logic [1:0] policy_q;
	logic [3:0] set_bits_q;
	logic [4:0] off_bits_q;
	logic [3:0] ways_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_LRU;
			set_bits_q <= 4'd8;
			off_bits_q <= 5'd0;
			ways_q <= 4'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POLICY:   policy_q <= cfg_data[1:0];
				REG_SET_BITS: set_bits_q <= cfg_data[3:0];
				REG_OFF_BITS: off_bits_q <= cfg_data;
				REG_WAYS:     ways_q <= cfg_data[3:0];
				default:      ;
			endcase
		end
	end

	// Address split.
	logic [ADDR_W-1:0] blk;
	logic [ADDR_W-1:0] set_full;
	logic [SW-1:0]     set_idx;
	logic [ADDR_W-1:0] tag_full;

	always_comb begin
		blk = (address >> ALIGN_BITS) >> off_bits_q;
		set_full = blk & ((ADDR_W'(1) << set_bits_q) - ADDR_W'(1));
		set_idx = SW'(set_full % SET_COUNT);
		tag_full = blk >> set_bits_q;
	end

	// Clearing pass after reset: one set per cycle through every way RAM.
	logic          clr_q;
	logic [SW-1:0] clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + SW'(1);
			if (clr_idx_q == SW'(SET_COUNT - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Stage one request registers.
	logic                 act_s1;
	logic [SW-1:0]        set_s1;
	logic [TAG_W-1:0]     tag_s1;
	logic [TS_W-1:0]      ts_s1;
	logic                 accept;

	assign accept = start && !busy;
	assign busy = act_s1 || clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
		end else begin
			act_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1 <= set_idx;
			tag_s1 <= tag_full[TAG_W-1:0];
			ts_s1 <= timestamp;
		end
	end

	// Ways in use, clamped to 1..WAY_COUNT.
	logic [WAY_COUNT-1:0] used;
	always_comb begin
		for (int b = 0; b < WAY_COUNT; b++) begin
			used[b] = (b == 0) || (b < int'(ways_q) && b < WAY_COUNT);
		end
	end

	// Metadata RAMs, one per way.
	way_meta_t            rd   [WAY_COUNT];
	way_meta_t            wd;
	way_meta_t            ram_wdata;
	logic [SW-1:0]        ram_waddr;
	logic [WAY_COUNT-1:0] we;
	logic [WAY_COUNT-1:0] vld_set;
	logic                 hit_c;
	logic [WW-1:0]        way_c;

	assign ram_waddr = clr_q ? clr_idx_q : set_s1;
	assign ram_wdata = clr_q ? '0 : wd;

	for (genvar g = 0; g < WAY_COUNT; g++) begin : g_way
		sacl_ram #(.WIDTH(META_W), .DEPTH(SET_COUNT)) u_ram (
			.clk  (clk),
			.we   (we[g]),
			.waddr(ram_waddr),
			.wdata(ram_wdata),
			.raddr(set_idx),
			.rdata(rd[g])
		);
	end

	// Valid bits of the set that was read.
	always_comb begin
		for (int b = 0; b < WAY_COUNT; b++) begin
			vld_set[b] = rd[b].vld;
		end
	end

	sacl_victim #(.WAY_COUNT(WAY_COUNT)) u_victim (
		.meta  (rd),
		.vld   (vld_set),
		.used  (used),
		.tag   (tag_s1),
		.policy(policy_q),
		.hit   (hit_c),
		.way   (way_c)
	);

	// Metadata update for the selected way.
	always_comb begin
		wd = rd[way_c];
		wd.vld = 1'b1;
		wd.tag = tag_s1;
		if (hit_c) begin
			if (policy_q inside {POL_LRU, POL_LFU}) begin
				wd.lat = ts_s1;
			end
			if (policy_q == POL_LFU && wd.cnt != '1) begin
				wd.cnt = wd.cnt + TS_W'(1);
			end
		end else begin
			case (policy_q)
				POL_LRU:  wd.lat = ts_s1;
				POL_LFU:  begin
					wd.cnt = TS_W'(1);
					wd.lat = ts_s1;
				end
				POL_FIFO: wd.fill = ts_s1;
				default:  ;
			endcase
		end
		we = '0;
		if (clr_q) begin
			we = '1;
		end else if (act_s1) begin
			we[way_c] = 1'b1;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= act_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (act_s1) begin
			hit <= hit_c;
			way <= 3'(way_c);
		end
	end

	// A request is never accepted while one is in flight.
	assert property (@(posedge clk) disable iff (!arst_n) act_s1 |-> !accept)
		else $error("request accepted while busy");
	// Each accepted request yields a result on done.
	assert property (@(posedge clk) disable iff (!arst_n) accept |-> ##2 done)
		else $error("missing result");
	// The chosen way is always one in use.
	assert property (@(posedge clk) disable iff (!arst_n) act_s1 |-> used[way_c])
		else $error("way out of range");
	// A hit reports a valid way.
	assert property (@(posedge clk) disable iff (!arst_n) (act_s1 && hit_c) |-> vld_set[way_c])
		else $error("hit on invalid way");
endmodule

>>> rtl/sacl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_ram
// Generic simple dual-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/sacl_victim.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_victim
// Hit search, empty-way search and victim choice over one read set.
// ----------------------------------------------------------------------------
module sacl_victim #(
	parameter int WAY_COUNT = sacl_pkg::WAY_COUNT_DEF
) (
	input  sacl_pkg::way_meta_t          meta [WAY_COUNT],
	input  logic [WAY_COUNT-1:0]         vld,
	input  logic [WAY_COUNT-1:0]         used,
	input  logic [sacl_pkg::TAG_W-1:0]   tag,
	input  logic [1:0]                   policy,
	output logic                         hit,
	output logic [$clog2(WAY_COUNT > 1 ? WAY_COUNT : 2)-1:0] way
);
	import sacl_pkg::*;
	localparam int WW = $clog2(WAY_COUNT > 1 ? WAY_COUNT : 2);

	logic [WW-1:0] hit_w, free_w, vic_w;
	logic          free_f;
	logic          better;

	// Priority searches; lowest way wins every tie.
	always_comb begin
		hit = 1'b0;
		hit_w = '0;
		free_f = 1'b0;
		free_w = '0;
		vic_w = '0;
		better = 1'b0;
		for (int b = WAY_COUNT - 1; b >= 0; b--) begin
			if (used[b] && vld[b] && meta[b].tag == tag) begin
				hit = 1'b1;
				hit_w = WW'(b);
			end
			if (used[b] && !vld[b]) begin
				free_f = 1'b1;
				free_w = WW'(b);
			end
		end
		for (int b = 1; b < WAY_COUNT; b++) begin
			case (policy)
				POL_LRU:  better = meta[b].lat < meta[vic_w].lat;
				POL_LFU:  better = (meta[b].cnt < meta[vic_w].cnt) ||
					(meta[b].cnt == meta[vic_w].cnt && meta[b].lat < meta[vic_w].lat);
				POL_FIFO: better = meta[b].fill < meta[vic_w].fill;
				default:  better = 1'b0;
			endcase
			if (used[b] && better) begin
				vic_w = WW'(b);
			end
		end
		way = hit ? hit_w : (free_f ? free_w : vic_w);
	end
endmodule
